### rtl/lcrc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lcrc_pkg;

  localparam logic [7:0]  NEWLINE_BYTE = 8'h0A;
  localparam logic [7:0]  TAG_COMMA    = 8'h2C;
  localparam logic [7:0]  TAG_C        = 8'h43;
  localparam logic [7:0]  TAG_R        = 8'h52;
  localparam logic [7:0]  TAG_COLON    = 8'h3A;
  localparam int          WIN_LEN      = 5;
  localparam int          HEX_LEN      = 8;
  localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY     = 32'h04C1_1DB7;

  // byte class decided by the front end
  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_TAG_END = 2'd1,
    KIND_NEWLINE = 2'd2
  } lcrc_kind_t;

  typedef struct packed {
    lcrc_kind_t  kind;
    logic [7:0]  data;
  } lcrc_entry_t;

  // MSB-first bytewise CRC-32 step
  function automatic logic [31:0] crc_update(input logic [31:0] crc_in,
                                             input logic [7:0]  byte_in);
    logic [31:0] c;
    logic        fb;
    c = crc_in;
    for (int i = 7; i >= 0; i--) begin
      fb = c[31] ^ byte_in[i];
      c  = {c[30:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] d;
    if (nib < 4'd10) begin
      d = 8'h30 + {4'h0, nib};
    end else begin
      d = 8'h37 + {4'h0, nib};
    end
    return d;
  endfunction

  // 8 uppercase ASCII hex digits, most significant nibble first
  function automatic logic [63:0] hex_of(input logic [31:0] v);
    logic [63:0] r;
    for (int i = 0; i < HEX_LEN; i++) begin
      r[8*i +: 8] = hex_digit(v[4*i +: 4]);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/lcrc_rx_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lcrc_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

### rtl/lcrc_res_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lcrc_res_if;
  logic        valid;
  logic        ready;
  logic        crc_ok;
  logic        tag_seen;
  logic [31:0] computed_crc;

  modport source (output valid, output crc_ok, output tag_seen, output computed_crc,
                  input ready);
  modport sink   (input valid, input crc_ok, input tag_seen, input computed_crc,
                  output ready);
endinterface

`default_nettype wire

### rtl/lcrc_front.sv
`timescale 1ns / 1ps
`default_nettype none

// Classifies each received byte: newline, plain data, or last byte of ",CRC:".
module lcrc_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire logic [7:0]           rx_byte,
  output lcrc_pkg::lcrc_entry_t     entry
);

  logic [2:0]  seen_cnt;     // bytes since line start, saturates at 4
  logic [31:0] last4;        // newest byte in [7:0]
  logic        is_nl;
  logic        is_tag;

  assign is_nl  = (rx_byte == lcrc_pkg::NEWLINE_BYTE);
  assign is_tag = (seen_cnt == 3'd4) &&
                  (last4 == {lcrc_pkg::TAG_COMMA, lcrc_pkg::TAG_C,
                             lcrc_pkg::TAG_R, lcrc_pkg::TAG_C}) &&
                  (rx_byte == lcrc_pkg::TAG_COLON);

  always_comb begin
    entry.data = rx_byte;
    if (is_nl) begin
      entry.kind = lcrc_pkg::KIND_NEWLINE;
    end else if (is_tag) begin
      entry.kind = lcrc_pkg::KIND_TAG_END;
    end else begin
      entry.kind = lcrc_pkg::KIND_DATA;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_cnt <= 3'd0;
    end else if (push) begin
      if (is_nl) begin
        seen_cnt <= 3'd0;
      end else if (seen_cnt != 3'd4) begin
        seen_cnt <= seen_cnt + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      last4 <= {last4[23:0], rx_byte};
    end
  end

endmodule

`default_nettype wire

### rtl/lcrc_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// Two-entry FIFO between front and back end.
module lcrc_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire lcrc_pkg::lcrc_entry_t push_entry,
  output logic                      can_push,
  input  wire logic                 pop,
  output logic                      can_pop,
  output lcrc_pkg::lcrc_entry_t     pop_entry
);

  lcrc_pkg::lcrc_entry_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign can_push  = (count != 2'd2);
  assign can_pop   = (count != 2'd0);
  assign pop_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

`default_nettype wire

### rtl/lcrc_back.sv
`timescale 1ns / 1ps
`default_nettype none

// CRC with a five-byte delay line, trailer capture and the per-line verdict.
module lcrc_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 can_pop,
  input  wire lcrc_pkg::lcrc_entry_t entry,
  output logic                      pop,
  lcrc_res_if.source                res
);

  logic [31:0] crc_run;
  logic [7:0]  win [lcrc_pkg::WIN_LEN];   // [0] oldest
  logic [2:0]  win_cnt;
  logic [31:0] crc_at_tag;
  logic [63:0] cap_hex;
  logic [3:0]  cap_cnt;
  logic        tag_found;

  logic        out_valid;
  logic        out_ok;
  logic        out_tag;
  logic [31:0] out_crc;

  logic        out_free;
  logic        is_nl;
  logic [31:0] crc_run_next;
  logic [31:0] crc_final;
  logic        ok_now;

  assign out_free = !out_valid || res.ready;
  assign is_nl    = (entry.kind == lcrc_pkg::KIND_NEWLINE);
  assign pop      = can_pop && (!is_nl || out_free);

  // oldest slot holds a real byte only once the line is five bytes deep
  assign crc_run_next = (win_cnt == 3'(lcrc_pkg::WIN_LEN)) ?
                        lcrc_pkg::crc_update(crc_run, win[0]) : crc_run;

  assign crc_final = tag_found ? ~crc_at_tag : 32'h0;
  assign ok_now    = tag_found && (cap_cnt == 4'(lcrc_pkg::HEX_LEN)) &&
                     (cap_hex == lcrc_pkg::hex_of(crc_final));

  assign res.valid        = out_valid;
  assign res.crc_ok       = out_ok;
  assign res.tag_seen     = out_tag;
  assign res.computed_crc = out_crc;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_run    <= lcrc_pkg::CRC_INIT;
      win_cnt    <= 3'd0;
      crc_at_tag <= 32'h0;
      cap_hex    <= 64'h0;
      cap_cnt    <= 4'd0;
      tag_found  <= 1'b0;
    end else if (pop) begin
      case (entry.kind)
        lcrc_pkg::KIND_NEWLINE: begin
          crc_run    <= lcrc_pkg::CRC_INIT;
          win_cnt    <= 3'd0;
          crc_at_tag <= 32'h0;
          cap_hex    <= 64'h0;
          cap_cnt    <= 4'd0;
          tag_found  <= 1'b0;
        end
        lcrc_pkg::KIND_TAG_END: begin
          crc_run    <= crc_run_next;
          win_cnt    <= 3'(lcrc_pkg::WIN_LEN);
          crc_at_tag <= crc_run_next;
          cap_hex    <= 64'h0;
          cap_cnt    <= 4'd0;
          tag_found  <= 1'b1;
        end
        default: begin
          crc_run <= crc_run_next;
          if (win_cnt != 3'(lcrc_pkg::WIN_LEN)) begin
            win_cnt <= win_cnt + 3'd1;
          end
          if (tag_found && (cap_cnt < 4'(lcrc_pkg::HEX_LEN))) begin
            cap_hex <= {cap_hex[55:0], entry.data};
            cap_cnt <= cap_cnt + 4'd1;
          end
        end
      endcase
    end
  end

  // delay line shifts on every popped non-newline byte; real bytes sit in the top win_cnt slots
  always_ff @(posedge clk) begin
    if (pop && !is_nl) begin
      for (int i = 0; i < lcrc_pkg::WIN_LEN - 1; i++) begin
        win[i] <= win[i+1];
      end
      win[lcrc_pkg::WIN_LEN-1] <= entry.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && is_nl) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && is_nl) begin
      out_ok  <= ok_now;
      out_tag <= tag_found;
      out_crc <= crc_final;
    end
  end

endmodule

`default_nettype wire

### rtl/line_crc32_frame_checker.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Payload                              Transaction
// rx       in   rx_byte[7:0]                         one received character
// res      out  crc_ok, tag_seen, computed_crc[31:0] one verdict per newline
//
// One byte per cycle sustained while the queue has room; a byte passes front
// end, 2-entry queue and back end, so a newline is written into the queue and,
// when nothing waits ahead of it, popped into the output register, raising res.valid.
// The bytewise CRC-32 step in the back end is the longest path.
// Synchronous reset clears the queue, line state and the output valid flag.
// rx stalls only when the queue is full; the back end stalls only on a
// newline while an unclaimed verdict still sits in the output register.
module line_crc32_frame_checker (
  input  wire logic   clk,
  input  wire logic   rst,
  lcrc_rx_if.sink     rx,
  lcrc_res_if.source  res
);

  lcrc_pkg::lcrc_entry_t front_entry;
  lcrc_pkg::lcrc_entry_t back_entry;
  logic                  q_can_push;
  logic                  q_can_pop;
  logic                  q_pop;
  logic                  rx_take;

  assign rx.ready = q_can_push;
  assign rx_take  = rx.valid && q_can_push;

  lcrc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (rx_take),
    .rx_byte (rx.rx_byte),
    .entry   (front_entry)
  );

  lcrc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (rx_take),
    .push_entry (front_entry),
    .can_push   (q_can_push),
    .pop        (q_pop),
    .can_pop    (q_can_pop),
    .pop_entry  (back_entry)
  );

  lcrc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .can_pop (q_can_pop),
    .entry   (back_entry),
    .pop     (q_pop),
    .res     (res)
  );

endmodule

`default_nettype wire

### sim/line_crc32_frame_checker_test.sv
`timescale 1ns / 1ps

module line_crc32_frame_checker_test;

  // Predicts one verdict per line and checks verdicts in arrival order.
  class line_verdict_board;
    typedef struct packed {
      logic        ok;
      logic        tag;
      logic [31:0] crc;
    } verdict_t;

    verdict_t    due[$];
    logic [31:0] crc_lagged;
    logic [31:0] crc_at_tag;
    logic [7:0]  window[lcrc_pkg::WIN_LEN];
    int unsigned window_fill;
    logic [63:0] trailer;
    int unsigned trailer_len;
    bit          tag_hit;
    int          errors;
    int          lines;
    int          tag_lines;
    int          passed;

    function new();
      errors    = 0;
      lines     = 0;
      tag_lines = 0;
      passed    = 0;
      clear_line();
    endfunction

    static function logic [31:0] crc_step(logic [31:0] c, logic [7:0] d);
      c = c ^ {d, 24'h0};
      for (int i = 0; i < 8; i++) begin
        c = c[31] ? ((c << 1) ^ lcrc_pkg::CRC_POLY) : (c << 1);
      end
      return c;
    endfunction

    static function logic [63:0] hex_text(logic [31:0] v, bit lower);
      logic [63:0] r;
      logic [3:0]  nib;
      logic [7:0]  d;
      r = 64'h0;
      for (int i = 7; i >= 0; i--) begin
        nib = v[4*i +: 4];
        if (nib < 4'd10) begin
          d = 8'h30 + {4'h0, nib};
        end else begin
          d = (lower ? 8'h61 : 8'h41) + {4'h0, nib} - 8'd10;
        end
        r = {r[55:0], d};
      end
      return r;
    endfunction

    function void clear_line();
      crc_lagged = lcrc_pkg::CRC_INIT;
      foreach (window[i]) window[i] = 8'h00;
      window_fill = 0;
      crc_at_tag  = 32'h0;
      trailer     = 64'h0;
      trailer_len = 0;
      tag_hit     = 1'b0;
    endfunction

    function void note_byte(logic [7:0] d);
      verdict_t v;
      if (d == lcrc_pkg::NEWLINE_BYTE) begin
        v.tag = tag_hit;
        v.crc = tag_hit ? ~crc_at_tag : 32'h0;
        v.ok  = tag_hit && trailer_len == lcrc_pkg::HEX_LEN &&
                trailer == hex_text(v.crc, 1'b0);
        due = {due, v};
        lines++;
        tag_lines += tag_hit;
        passed += v.ok;
        clear_line();
      end else begin
        if (tag_hit && trailer_len < lcrc_pkg::HEX_LEN) begin
          trailer = {trailer[55:0], d};
          trailer_len++;
        end
        // CRC trails the input by the window, so at a tag match it covers
        // exactly the bytes in front of the tag
        if (window_fill == lcrc_pkg::WIN_LEN) begin
          crc_lagged = crc_step(crc_lagged, window[0]);
          for (int i = 0; i < lcrc_pkg::WIN_LEN - 1; i++) window[i] = window[i+1];
          window[lcrc_pkg::WIN_LEN-1] = d;
        end else begin
          window[window_fill] = d;
          window_fill++;
        end
        if (window_fill == lcrc_pkg::WIN_LEN &&
            window[0] == lcrc_pkg::TAG_COMMA && window[1] == lcrc_pkg::TAG_C &&
            window[2] == lcrc_pkg::TAG_R && window[3] == lcrc_pkg::TAG_C &&
            window[4] == lcrc_pkg::TAG_COLON) begin
          tag_hit     = 1'b1;
          crc_at_tag  = crc_lagged;
          trailer     = 64'h0;
          trailer_len = 0;
        end
      end
    endfunction

    function void check_verdict(logic ok, logic tag, logic [31:0] crc);
      verdict_t v;
      if (due.size() == 0) begin
        $error("verdict with none outstanding: crc_ok=%0d tag_seen=%0d computed_crc=%08h",
               ok, tag, crc);
        errors++;
      end else begin
        v = due.pop_front();
        if (ok !== v.ok) begin
          $error("crc_ok: expected %0d, actual %0d", v.ok, ok);
          errors++;
        end
        if (tag !== v.tag) begin
          $error("tag_seen: expected %0d, actual %0d", v.tag, tag);
          errors++;
        end
        if (crc !== v.crc) begin
          $error("computed_crc: expected %08h, actual %08h", v.crc, crc);
          errors++;
        end
      end
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

  localparam int STALL_LIMIT = 2000;
  localparam int BYTE_TARGET = 1600;

  logic clk;
  logic rst;
  bit   calm;
  int   bytes_sent;
  int   lines_sent;
  int   idle_cycles;
  logic [7:0] line_buf[$];
  line_verdict_board board;

  lcrc_rx_if  rx_ch ();
  lcrc_res_if res_ch ();

  line_crc32_frame_checker dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .res (res_ch)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Acceptance monitor, checker and watchdog
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (rx_ch.valid && rx_ch.ready) board.note_byte(rx_ch.rx_byte);
      if (res_ch.valid && res_ch.ready)
        board.check_verdict(res_ch.crc_ok, res_ch.tag_seen, res_ch.computed_crc);
      if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("line_crc32_frame_checker: mismatch");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Result side back-pressure
  initial begin
    int gap;
    res_ch.ready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] d);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= d;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_line();
    foreach (line_buf[i]) send_byte(line_buf[i]);
    send_byte(lcrc_pkg::NEWLINE_BYTE);
    line_buf.delete();
    lines_sent++;
  endtask

  task automatic drain_results();
    rx_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic add_byte(input logic [7:0] d);
    line_buf = {line_buf, d};
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(8'(s[i]));
  endtask

  task automatic put_tag();
    add_byte(lcrc_pkg::TAG_COMMA);
    add_byte(lcrc_pkg::TAG_C);
    add_byte(lcrc_pkg::TAG_R);
    add_byte(lcrc_pkg::TAG_C);
    add_byte(lcrc_pkg::TAG_COLON);
  endtask

  // random bytes, mostly printable unless any_value is set; never a newline
  task automatic put_payload(input int n, input bit any_value);
    logic [7:0] d;
    for (int i = 0; i < n; i++) begin
      if (any_value || $urandom_range(0, 9) == 0) d = 8'($urandom_range(0, 255));
      else d = 8'($urandom_range(32, 126));
      if (d == lcrc_pkg::NEWLINE_BYTE) d = d + 8'd1;
      add_byte(d);
    end
  endtask

  // tag plus the first count hex digits of the CRC of everything so far, one bit flipped if flip
  task automatic put_trailer(input bit lower, input int count, input bit flip);
    logic [31:0] c;
    logic [63:0] h;
    int          k;
    c = lcrc_pkg::CRC_INIT;
    foreach (line_buf[i]) c = line_verdict_board::crc_step(c, line_buf[i]);
    h = line_verdict_board::hex_text(~c, lower);
    if (flip) begin
      k = $urandom_range(0, 7);
      h[8*k +: 8] = h[8*k +: 8] ^ (8'h01 << $urandom_range(0, 7));
    end
    put_tag();
    for (int i = 0; i < count; i++) add_byte(h[63 - 8*i -: 8]);
  endtask

  task automatic random_line();
    int r;
    int n;
    r = $urandom_range(0, 99);
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) : $urandom_range(0, 24);
    put_payload(n, 1'b0);
    if (r < 55) begin
      put_trailer(1'b0, lcrc_pkg::HEX_LEN, 1'b0);
    end else if (r < 63) begin
      put_trailer(1'b0, lcrc_pkg::HEX_LEN, 1'b1);
    end else if (r < 70) begin
      put_trailer(1'b1, lcrc_pkg::HEX_LEN, 1'b0);
    end else if (r < 78) begin
      put_trailer(1'b0, $urandom_range(0, lcrc_pkg::HEX_LEN - 1), 1'b0);
    end else if (r < 85) begin
      put_trailer(1'b0, $urandom_range(0, lcrc_pkg::HEX_LEN), 1'($urandom_range(0, 1)));
      put_payload($urandom_range(0, 12), 1'b0);
      put_trailer(1'b0, lcrc_pkg::HEX_LEN, 1'b0);
    end else if (r < 90) begin
      put_trailer(1'b0, lcrc_pkg::HEX_LEN, 1'b0);
      put_payload($urandom_range(1, 6), 1'b0);
    end else if (r < 95) begin
      if ($urandom_range(0, 1)) put_text("CRC:");
      put_payload($urandom_range(0, 10), 1'b0);
    end else begin
      put_payload($urandom_range(0, 20), 1'b1);
      if ($urandom_range(0, 1)) begin
        put_tag();
        put_payload(lcrc_pkg::HEX_LEN, 1'b1);
      end
    end
    send_line();
  endtask

  initial begin
    board         = new();
    calm          = 1'b0;
    bytes_sent    = 0;
    lines_sent    = 0;
    rst           = 1'b1;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = 8'h00;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // empty line
    send_line();
    // empty data part
    put_trailer(1'b0, lcrc_pkg::HEX_LEN, 1'b0);
    send_line();
    // byte extremes in the data part
    add_byte(8'h00);
    add_byte(8'hFF);
    put_text("A");
    put_trailer(1'b0, lcrc_pkg::HEX_LEN, 1'b0);
    send_line();
    // short trailer, and a tag right before the newline
    put_text("x");
    put_trailer(1'b0, 1, 1'b0);
    send_line();
    put_text("9");
    put_tag();
    send_line();
    // extra bytes after the hex
    put_text("ab");
    put_trailer(1'b0, lcrc_pkg::HEX_LEN, 1'b0);
    put_text("ZZ");
    send_line();
    // lowercase digits
    put_text("hello");
    put_trailer(1'b1, lcrc_pkg::HEX_LEN, 1'b0);
    send_line();
    // later tag replaces the first one
    put_text("p1");
    put_trailer(1'b0, lcrc_pkg::HEX_LEN, 1'b0);
    put_text("q2");
    put_trailer(1'b0, lcrc_pkg::HEX_LEN, 1'b0);
    send_line();
    // non-hex trailer
    put_text("n");
    put_tag();
    put_text("GGGGGGGG");
    send_line();
    // tag without its comma
    put_text("CRC:12345678");
    send_line();
    // doubled comma in front of the tag
    put_text(",");
    put_trailer(1'b0, lcrc_pkg::HEX_LEN, 1'b0);
    send_line();
    // one wrong bit in the hex
    put_text("A");
    put_trailer(1'b0, lcrc_pkg::HEX_LEN, 1'b1);
    send_line();
    drain_results();

    while (bytes_sent < BYTE_TARGET) begin
      if ($urandom_range(0, 9) == 0) calm = !calm;
      random_line();
      if ($urandom_range(0, 14) == 0) drain_results();
    end
    rx_ch.valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("%0d bytes in %0d lines: %0d with a tag, %0d with a matching CRC",
             bytes_sent, board.lines, board.tag_lines, board.passed);
    $display("lines covered good, corrupted, lowercase, short, repeated-tag and noise trailers");
    if (board.errors == 0) begin
      $display("line_crc32_frame_checker: match");
    end else begin
      $display("line_crc32_frame_checker: mismatch");
    end
    $finish;
  end

endmodule
